// ===== src/ncomix_pkg.sv =====
// ----------------------------------------------------------------------------
// ncomix_pkg: shared types and constants for the nco mixer channel
// Register codes, default parameters, gain settings bundle and the
// quarter-wave sine table generator used at elaboration.
// ----------------------------------------------------------------------------
package ncomix_pkg;

    localparam int TABLE_BITS_DEF   = 10;
    localparam int SAMPLE_WIDTH_DEF = 16;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 2;
    localparam int NOISE_W     = 16;
    localparam int GAIN_W      = 16;
    localparam int PHASE_W     = 32;

    localparam logic [GAIN_W-1:0] GAIN_RESET = 16'd256;

    // request queue between front and back, power of two
    localparam int QUEUE_DEPTH = 4;
    // rom read, products, sums, gain products, output register
    localparam int PIPE_DEPTH  = 5;
    localparam int MAX_INFLIGHT = QUEUE_DEPTH + PIPE_DEPTH;
    localparam int INFLIGHT_W   = $clog2(MAX_INFLIGHT + 1);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_TARGET_STEP = 2'd0,
        REG_SMOOTHING   = 2'd1,
        REG_SIGNAL_GAIN = 2'd2,
        REG_NOISE_SCALE = 2'd3
    } cfg_reg_t;

    typedef struct packed {
        logic [GAIN_W-1:0] signal_gain;
        logic [GAIN_W-1:0] noise_scale;
    } gain_cfg_t;

    // sin(k * pi/2 / 2^tb) in q1.15, polynomial in q30
    function automatic logic [15:0] sine_entry(input int unsigned k, input int unsigned tb);
        logic [63:0] a;
        logic [63:0] a2;
        logic [63:0] t;
        logic [63:0] s;
        logic [63:0] e;
        logic [63:0] one;
        one = 64'd1 << 30;
        a   = (64'(k) * 64'd1686629713) >> tb;
        a2  = (a * a) >> 30;
        t   = one;
        t   = one - (((a2 * t) >> 30) / 64'd156);
        t   = one - (((a2 * t) >> 30) / 64'd110);
        t   = one - (((a2 * t) >> 30) / 64'd72);
        t   = one - (((a2 * t) >> 30) / 64'd42);
        t   = one - (((a2 * t) >> 30) / 64'd20);
        t   = one - (((a2 * t) >> 30) / 64'd6);
        s   = (a * t) >> 30;
        e   = (s * 64'd32767 + (64'd1 << 29)) >> 30;
        return e[15:0];
    endfunction

endpackage

// ===== src/ncomix_front.sv =====
// ----------------------------------------------------------------------------
// ncomix_front: request intake and oscillator control
// Holds the configuration registers, takes requests into the queue tagged
// with the current phase, then advances phase and the smoothed frequency step.
// ----------------------------------------------------------------------------
module ncomix_front #(
    parameter int TABLE_BITS   = ncomix_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_WIDTH = ncomix_pkg::SAMPLE_WIDTH_DEF,
    parameter int ENTRY_W      = TABLE_BITS + 2 + 2 * SAMPLE_WIDTH + 2 * ncomix_pkg::NOISE_W + 1
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [ncomix_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [ncomix_pkg::CFG_DATA_W-1:0]       cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]          in_i,
    input  logic signed [SAMPLE_WIDTH-1:0]          in_q,
    input  logic signed [ncomix_pkg::NOISE_W-1:0]   noise_i,
    input  logic signed [ncomix_pkg::NOISE_W-1:0]   noise_q,
    input  logic                                    last_in,
    input  logic                                    q_full,
    output logic                                    q_push,
    output logic [ENTRY_W-1:0]                      q_push_data,
    output ncomix_pkg::gain_cfg_t                   gain_cfg
);

    localparam int PW = ncomix_pkg::PHASE_W;
    localparam int GW = ncomix_pkg::GAIN_W;

    logic [PW-1:0] target_reg;
    logic [GW-1:0] smoothing_reg;
    logic [GW-1:0] signal_gain_reg;
    logic [GW-1:0] noise_scale_reg;
    logic [PW-1:0] phase_reg;
    logic [PW-1:0] phase_next;
    logic [PW-1:0] freq_reg;
    logic [PW-1:0] freq_next;

    logic signed [PW:0]          diff;
    logic signed [PW+GW+1:0]     prod;
    logic signed [PW+GW+1:0]     rounded;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg      <= '0;
            smoothing_reg   <= '0;
            signal_gain_reg <= ncomix_pkg::GAIN_RESET;
            noise_scale_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (ncomix_pkg::cfg_reg_t'(cfg_addr))
                ncomix_pkg::REG_TARGET_STEP: target_reg      <= cfg_wdata[PW-1:0];
                ncomix_pkg::REG_SMOOTHING:   smoothing_reg   <= cfg_wdata[GW-1:0];
                ncomix_pkg::REG_SIGNAL_GAIN: signal_gain_reg <= cfg_wdata[GW-1:0];
                ncomix_pkg::REG_NOISE_SCALE: noise_scale_reg <= cfg_wdata[GW-1:0];
            endcase
        end
    end

    assign in_ready = !q_full;
    assign q_push   = in_valid && !q_full;
    assign q_push_data = {phase_reg[PW-1 -: TABLE_BITS + 2], in_i, in_q, noise_i, noise_q,
                          last_in};

    assign gain_cfg.signal_gain = signal_gain_reg;
    assign gain_cfg.noise_scale = noise_scale_reg;

    // one-pole ramp of the step toward the target, rounded half up
    always_comb
    begin
        diff       = {target_reg[PW-1], target_reg} - {freq_reg[PW-1], freq_reg};
        prod       = diff * $signed({1'b0, smoothing_reg});
        rounded    = prod + (PW+GW+2)'(32768);
        freq_next  = freq_reg + rounded[PW+15:16];
        phase_next = phase_reg + freq_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= '0;
            freq_reg  <= '0;
        end
        else if (q_push)
        begin
            phase_reg <= phase_next;
            freq_reg  <= freq_next;
        end
    end

endmodule

// ===== src/ncomix_queue.sv =====
// ----------------------------------------------------------------------------
// ncomix_queue: short request queue
// Decouples intake from the mixing pipeline so each side stalls on its own.
// ----------------------------------------------------------------------------
module ncomix_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = ncomix_pkg::QUEUE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output logic [WIDTH-1:0] head_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] cnt_next;

    assign full       = (cnt_reg == CNT_W'(DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_data  = mem[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            cnt_reg <= cnt_next;
        end
    end

endmodule

// ===== src/ncomix_sine_rom.sv =====
// ----------------------------------------------------------------------------
// ncomix_sine_rom: quarter-wave sine table
// Two registered read ports, one for sin and one for cos magnitude.
// ----------------------------------------------------------------------------
module ncomix_sine_rom #(
    parameter int TABLE_BITS = ncomix_pkg::TABLE_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic [TABLE_BITS:0]   addr_a,
    input  logic [TABLE_BITS:0]   addr_b,
    output logic [15:0]           data_a,
    output logic [15:0]           data_b
);

    localparam int N = 1 << TABLE_BITS;

    logic [15:0] rom [N + 1];

    for (genvar k = 0; k <= N; k++)
    begin : g_rom
        assign rom[k] = ncomix_pkg::sine_entry(k, TABLE_BITS);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_a <= rom[addr_a];
            data_b <= rom[addr_b];
        end
    end

endmodule

// ===== src/ncomix_back.sv =====
// ----------------------------------------------------------------------------
// ncomix_back: mixing, gain and noise pipeline
// Five stalling stages: table read, rotation products, sums, gain products,
// noise add with rounding and saturation into the output register.
// ----------------------------------------------------------------------------
module ncomix_back #(
    parameter int TABLE_BITS   = ncomix_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_WIDTH = ncomix_pkg::SAMPLE_WIDTH_DEF,
    parameter int ENTRY_W      = TABLE_BITS + 2 + 2 * SAMPLE_WIDTH + 2 * ncomix_pkg::NOISE_W + 1
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           q_valid,
    input  logic [ENTRY_W-1:0]             q_data,
    output logic                           q_pop,
    input  ncomix_pkg::gain_cfg_t          gain_cfg,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic signed [SAMPLE_WIDTH-1:0] out_i,
    output logic signed [SAMPLE_WIDTH-1:0] out_q,
    output logic                           last_out
);

    localparam int SW    = SAMPLE_WIDTH;
    localparam int NW    = ncomix_pkg::NOISE_W;
    localparam int GW    = ncomix_pkg::GAIN_W;
    localparam int PRW   = SW + 16;
    localparam int SUMW  = SW + 17;
    localparam int GPW   = SUMW + GW + 1;
    localparam int NPW   = NW + GW + 1;
    localparam int ACC_W = SW + 36;
    localparam int RW    = ACC_W - 23;

    typedef enum logic [1:0] {QUAD_0, QUAD_1, QUAD_2, QUAD_3} quad_t;

    localparam logic signed [RW-1:0] SAT_MAX = {{(RW-SW+1){1'b0}}, {(SW-1){1'b1}}};
    localparam logic signed [RW-1:0] SAT_MIN = {{(RW-SW+1){1'b1}}, {(SW-1){1'b0}}};

    function automatic logic [SW-1:0] round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] biased;
        logic signed [RW-1:0]    r;
        logic [SW-1:0]           res;
        biased = acc + ACC_W'(1 << 22);
        r      = biased[ACC_W-1:23];
        if (r > SAT_MAX)
            res = SAT_MAX[SW-1:0];
        else if (r < SAT_MIN)
            res = SAT_MIN[SW-1:0];
        else
            res = r[SW-1:0];
        return res;
    endfunction

    logic advance;

    // queue head fields
    logic [TABLE_BITS+1:0]   h_phase;
    logic signed [SW-1:0]    h_i;
    logic signed [SW-1:0]    h_q;
    logic signed [NW-1:0]    h_ni;
    logic signed [NW-1:0]    h_nq;
    logic                    h_last;
    logic [TABLE_BITS:0]     addr_a;
    logic [TABLE_BITS:0]     addr_b;

    // stage 1: table read
    logic                    s1_valid_reg;
    quad_t                   s1_quad_reg;
    logic signed [SW-1:0]    s1_i_reg;
    logic signed [SW-1:0]    s1_q_reg;
    logic signed [NW-1:0]    s1_ni_reg;
    logic signed [NW-1:0]    s1_nq_reg;
    logic                    s1_last_reg;
    logic [15:0]             mag_a;
    logic [15:0]             mag_b;
    logic signed [15:0]      sin_v;
    logic signed [15:0]      cos_v;

    // stage 2: rotation products
    logic                    s2_valid_reg;
    logic signed [PRW-1:0]   s2_ic_reg;
    logic signed [PRW-1:0]   s2_qs_reg;
    logic signed [PRW-1:0]   s2_qc_reg;
    logic signed [PRW-1:0]   s2_is_reg;
    logic signed [NPW-1:0]   s2_ni_reg;
    logic signed [NPW-1:0]   s2_nq_reg;
    logic                    s2_last_reg;

    // stage 3: rotated sums
    logic                    s3_valid_reg;
    logic signed [SUMW-1:0]  s3_re_reg;
    logic signed [SUMW-1:0]  s3_im_reg;
    logic signed [NPW-1:0]   s3_ni_reg;
    logic signed [NPW-1:0]   s3_nq_reg;
    logic                    s3_last_reg;

    // stage 4: gain products
    logic                    s4_valid_reg;
    logic signed [GPW-1:0]   s4_re_reg;
    logic signed [GPW-1:0]   s4_im_reg;
    logic signed [NPW-1:0]   s4_ni_reg;
    logic signed [NPW-1:0]   s4_nq_reg;
    logic                    s4_last_reg;

    // output register
    logic                    out_valid_reg;
    logic [SW-1:0]           out_i_reg;
    logic [SW-1:0]           out_q_reg;
    logic                    last_out_reg;
    logic signed [ACC_W-1:0] acc_i;
    logic signed [ACC_W-1:0] acc_q;
    logic [SW-1:0]           out_i_next;
    logic [SW-1:0]           out_q_next;

    // whole pipeline moves unless a result is held at the output
    assign advance = !out_valid_reg || out_ready;
    assign q_pop   = advance && q_valid;

    assign {h_phase, h_i, h_q, h_ni, h_nq, h_last} = q_data;
    assign addr_a = {1'b0, h_phase[TABLE_BITS-1:0]};
    assign addr_b = {1'b1, {TABLE_BITS{1'b0}}} - {1'b0, h_phase[TABLE_BITS-1:0]};

    ncomix_sine_rom #(
        .TABLE_BITS (TABLE_BITS)
    ) u_rom (
        .clk    (clk),
        .en     (advance),
        .addr_a (addr_a),
        .addr_b (addr_b),
        .data_a (mag_a),
        .data_b (mag_b)
    );

    // quadrant folding of the quarter-wave magnitudes
    always_comb
    begin
        unique case (s1_quad_reg)
            QUAD_0:
            begin
                sin_v = $signed(mag_a);
                cos_v = $signed(mag_b);
            end
            QUAD_1:
            begin
                sin_v = $signed(mag_b);
                cos_v = -$signed(mag_a);
            end
            QUAD_2:
            begin
                sin_v = -$signed(mag_a);
                cos_v = -$signed(mag_b);
            end
            QUAD_3:
            begin
                sin_v = -$signed(mag_b);
                cos_v = $signed(mag_a);
            end
        endcase
    end

    always_comb
    begin
        acc_i = ACC_W'(s4_re_reg) + (ACC_W'(s4_ni_reg) <<< (SW + 2));
        acc_q = ACC_W'(s4_im_reg) + (ACC_W'(s4_nq_reg) <<< (SW + 2));
        out_i_next = round_sat(acc_i);
        out_q_next = round_sat(acc_q);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_valid_reg  <= q_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            s4_valid_reg  <= s3_valid_reg;
            out_valid_reg <= s4_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_quad_reg <= quad_t'(h_phase[TABLE_BITS+1:TABLE_BITS]);
            s1_i_reg    <= h_i;
            s1_q_reg    <= h_q;
            s1_ni_reg   <= h_ni;
            s1_nq_reg   <= h_nq;
            s1_last_reg <= h_last;

            s2_ic_reg   <= s1_i_reg * cos_v;
            s2_qs_reg   <= s1_q_reg * sin_v;
            s2_qc_reg   <= s1_q_reg * cos_v;
            s2_is_reg   <= s1_i_reg * sin_v;
            s2_ni_reg   <= s1_ni_reg * $signed({1'b0, gain_cfg.noise_scale});
            s2_nq_reg   <= s1_nq_reg * $signed({1'b0, gain_cfg.noise_scale});
            s2_last_reg <= s1_last_reg;

            s3_re_reg   <= SUMW'(s2_ic_reg) + SUMW'(s2_qs_reg);
            s3_im_reg   <= SUMW'(s2_qc_reg) - SUMW'(s2_is_reg);
            s3_ni_reg   <= s2_ni_reg;
            s3_nq_reg   <= s2_nq_reg;
            s3_last_reg <= s2_last_reg;

            s4_re_reg   <= s3_re_reg * $signed({1'b0, gain_cfg.signal_gain});
            s4_im_reg   <= s3_im_reg * $signed({1'b0, gain_cfg.signal_gain});
            s4_ni_reg   <= s3_ni_reg;
            s4_nq_reg   <= s3_nq_reg;
            s4_last_reg <= s3_last_reg;

            out_i_reg    <= out_i_next;
            out_q_reg    <= out_q_next;
            last_out_reg <= s4_last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_i     = $signed(out_i_reg);
    assign out_q     = $signed(out_q_reg);
    assign last_out  = last_out_reg;

endmodule

// ===== src/nco_mixer_gain_noise_channel.sv =====
// ----------------------------------------------------------------------------
// nco_mixer_gain_noise_channel: frequency-shift, gain and noise channel model
// Requests pass the queue and the back pipeline to out_valid; one request per clock while in_ready is high.
// Rate is set by the phase and frequency-step update, done once per request.
// Reset (async, active low) loads register defaults, clears phase and step.
// ----------------------------------------------------------------------------
module nco_mixer_gain_noise_channel #(
    parameter int TABLE_BITS   = ncomix_pkg::TABLE_BITS_DEF,
    parameter int SAMPLE_WIDTH = ncomix_pkg::SAMPLE_WIDTH_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_we,
    input  logic [ncomix_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [ncomix_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]        in_i,
    input  logic signed [SAMPLE_WIDTH-1:0]        in_q,
    input  logic signed [ncomix_pkg::NOISE_W-1:0] noise_i,
    input  logic signed [ncomix_pkg::NOISE_W-1:0] noise_q,
    input  logic                                  last_in,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [SAMPLE_WIDTH-1:0]        out_i,
    output logic signed [SAMPLE_WIDTH-1:0]        out_q,
    output logic                                  last_out
);

    localparam int ENTRY_W = TABLE_BITS + 2 + 2 * SAMPLE_WIDTH + 2 * ncomix_pkg::NOISE_W + 1;

    logic                  q_full;
    logic                  q_push;
    logic [ENTRY_W-1:0]    q_push_data;
    logic                  q_pop;
    logic                  q_valid;
    logic [ENTRY_W-1:0]    q_data;
    ncomix_pkg::gain_cfg_t gain_cfg;

    ncomix_front #(
        .TABLE_BITS   (TABLE_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ENTRY_W      (ENTRY_W)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_i        (in_i),
        .in_q        (in_q),
        .noise_i     (noise_i),
        .noise_q     (noise_q),
        .last_in     (last_in),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_push_data (q_push_data),
        .gain_cfg    (gain_cfg)
    );

    ncomix_queue #(
        .WIDTH (ENTRY_W),
        .DEPTH (ncomix_pkg::QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_data  (q_push_data),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_valid),
        .head_data  (q_data)
    );

    ncomix_back #(
        .TABLE_BITS   (TABLE_BITS),
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .ENTRY_W      (ENTRY_W)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_data    (q_data),
        .q_pop     (q_pop),
        .gain_cfg  (gain_cfg),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_i     (out_i),
        .out_q     (out_q),
        .last_out  (last_out)
    );

endmodule

// ===== src/ncomix_checker.sv =====
// ----------------------------------------------------------------------------
// ncomix_checker: port-level checks for the nco mixer channel
// Tracks requests in flight and checks output hold and backpressure.
// ----------------------------------------------------------------------------
module ncomix_checker #(
    parameter int SAMPLE_WIDTH = ncomix_pkg::SAMPLE_WIDTH_DEF
) (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  in_valid,
    input logic                                  in_ready,
    input logic                                  out_valid,
    input logic                                  out_ready,
    input logic signed [SAMPLE_WIDTH-1:0]        out_i,
    input logic signed [SAMPLE_WIDTH-1:0]        out_q,
    input logic                                  last_out
);

    localparam int IW = ncomix_pkg::INFLIGHT_W;

    logic          in_fire;
    logic          out_fire;
    logic [IW-1:0] inflight_reg;
    logic [IW-1:0] inflight_next;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_fire && !out_fire)
            inflight_next = inflight_reg + 1'b1;
        else if (out_fire && !in_fire)
            inflight_next = inflight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            inflight_reg <= '0;
        else
            inflight_reg <= inflight_next;
    end

    // a held result keeps its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_i) && $stable(out_q)
                                    && $stable(last_out))
        else $error("output changed while stalled");

    // no result without a request behind it
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> inflight_reg != '0)
        else $error("result shown with no request in flight");

    a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        inflight_reg <= IW'(ncomix_pkg::MAX_INFLIGHT))
        else $error("more requests in flight than storage");

    // backpressure only once the queue really holds its depth
    a_ready_low: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> inflight_reg >= IW'(ncomix_pkg::QUEUE_DEPTH))
        else $error("input stalled with queue not full");

endmodule

bind nco_mixer_gain_noise_channel ncomix_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_ncomix_checker (.*);

// ===== dv/mixer_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mixer_checker: scoreboard for the nco mixer channel
// Follows register writes and accepted requests, keeps its own phase and
// frequency ramp, predicts each mixed sample and compares it field by field
// with the oldest prediction when the sample leaves the block.
// ----------------------------------------------------------------------------
module mixer_checker (
    input  logic                                             clk,
    input  logic                                             rst_n,
    input  logic                                             cfg_we,
    input  logic [ncomix_pkg::CFG_ADDR_W-1:0]                cfg_addr,
    input  logic [ncomix_pkg::CFG_DATA_W-1:0]                cfg_wdata,
    input  logic                                             in_valid,
    input  logic                                             in_ready,
    input  logic signed [ncomix_pkg::SAMPLE_WIDTH_DEF-1:0]   in_i,
    input  logic signed [ncomix_pkg::SAMPLE_WIDTH_DEF-1:0]   in_q,
    input  logic signed [ncomix_pkg::NOISE_W-1:0]            noise_i,
    input  logic signed [ncomix_pkg::NOISE_W-1:0]            noise_q,
    input  logic                                             last_in,
    input  logic                                             out_valid,
    input  logic                                             out_ready,
    input  logic signed [ncomix_pkg::SAMPLE_WIDTH_DEF-1:0]   out_i,
    input  logic signed [ncomix_pkg::SAMPLE_WIDTH_DEF-1:0]   out_q,
    input  logic                                             last_out,
    output int                                               errors,
    output int                                               pending
);

    localparam int TB_BITS = ncomix_pkg::TABLE_BITS_DEF;
    localparam int SW      = ncomix_pkg::SAMPLE_WIDTH_DEF;
    localparam int N       = 1 << TB_BITS;
    localparam int GW      = ncomix_pkg::GAIN_W;

    typedef struct packed {
        logic signed [SW-1:0] re;
        logic signed [SW-1:0] im;
        logic                 last;
    } mixed_sample_t;

    logic [15:0]     quarter_sine [0:N];
    mixed_sample_t   expected_samples [$];

    logic [31:0]   target_step;
    logic [31:0]   freq_step;
    logic [31:0]   phase_acc;
    logic [GW-1:0] smoothing;
    logic [GW-1:0] signal_gain;
    logic [GW-1:0] noise_scale;

    // quarter-wave sine in q1.15 from a q30 odd polynomial
    initial
    begin : build_sine
        longint unsigned a;
        longint unsigned a2;
        longint unsigned t;
        longint unsigned s;
        longint unsigned divisors [6];
        divisors = '{64'd156, 64'd110, 64'd72, 64'd42, 64'd20, 64'd6};
        for (int k = 0; k <= N; k++)
        begin
            a  = (64'(k) * 64'd1686629713) >> TB_BITS;
            a2 = (a * a) >> 30;
            t  = 64'd1 << 30;
            for (int j = 0; j < 6; j++)
                t = (64'd1 << 30) - (((a2 * t) >> 30) / divisors[j]);
            s = (a * t) >> 30;
            quarter_sine[k] = 16'((s * 64'd32767 + (64'd1 << 29)) >> 30);
        end
    end

    function automatic logic signed [SW-1:0] clip(longint v);
        longint hi;
        longint lo;
        hi = (longint'(1) << (SW - 1)) - 1;
        lo = -(longint'(1) << (SW - 1));
        if (v > hi)
            v = hi;
        else if (v < lo)
            v = lo;
        return v[SW-1:0];
    endfunction

    function automatic mixed_sample_t mix_sample(logic signed [SW-1:0] xi,
                                                 logic signed [SW-1:0] xq,
                                                 logic signed [15:0] ni,
                                                 logic signed [15:0] nq,
                                                 logic last, logic [31:0] phase);
        longint        s;
        longint        c;
        longint        re;
        longint        im;
        longint        nmul;
        int unsigned   idx;
        mixed_sample_t r;
        idx = phase[29 -: TB_BITS];
        case (phase[31:30])
            2'd0:
            begin
                s =  quarter_sine[idx];
                c =  quarter_sine[N - idx];
            end
            2'd1:
            begin
                s =  quarter_sine[N - idx];
                c = -quarter_sine[idx];
            end
            2'd2:
            begin
                s = -quarter_sine[idx];
                c = -quarter_sine[N - idx];
            end
            default:
            begin
                s = -quarter_sine[N - idx];
                c =  quarter_sine[idx];
            end
        endcase
        nmul = longint'(noise_scale) * (longint'(1) << (SW + 2));
        re = (longint'(xi) * c + longint'(xq) * s) * longint'(signal_gain)
             + longint'(ni) * nmul;
        im = (longint'(xq) * c - longint'(xi) * s) * longint'(signal_gain)
             + longint'(nq) * nmul;
        r.re   = clip((re + (longint'(1) << 22)) >>> 23);
        r.im   = clip((im + (longint'(1) << 22)) >>> 23);
        r.last = last;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        mixed_sample_t want;
        mixed_sample_t got;
        longint        f;
        longint        t;
        if (!rst_n)
        begin
            target_step <= '0;
            smoothing   <= '0;
            signal_gain <= ncomix_pkg::GAIN_RESET;
            noise_scale <= '0;
            phase_acc   <= '0;
            freq_step   <= '0;
            expected_samples.delete();
            pending     <= 0;
            errors      <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_addr)
                    ncomix_pkg::REG_TARGET_STEP: target_step <= cfg_wdata;
                    ncomix_pkg::REG_SMOOTHING:   smoothing   <= cfg_wdata[GW-1:0];
                    ncomix_pkg::REG_SIGNAL_GAIN: signal_gain <= cfg_wdata[GW-1:0];
                    ncomix_pkg::REG_NOISE_SCALE: noise_scale <= cfg_wdata[GW-1:0];
                    default: ;
                endcase
            end
            // retire before predicting so a sample never meets its own request
            if (out_valid && out_ready)
            begin
                got = '{re: out_i, im: out_q, last: last_out};
                if (expected_samples.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected sample: i=%0d q=%0d last=%b",
                                 got.re, got.im, got.last);
                    errors <= errors + 1;
                end
                else
                begin
                    want = expected_samples.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                            $display("mismatch: exp i=%0d q=%0d last=%b, got i=%0d q=%0d last=%b",
                                     want.re, want.im, want.last,
                                     got.re, got.im, got.last);
                        errors <= errors + 1;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                expected_samples.push_back(mix_sample(in_i, in_q, noise_i, noise_q,
                                                      last_in, phase_acc));
                phase_acc <= phase_acc + freq_step;
                f = longint'(signed'(freq_step));
                t = longint'(signed'(target_step));
                f = f + (((t - f) * longint'(smoothing) + (longint'(1) << 15)) >>> 16);
                freq_step <= f[31:0];
            end
            pending <= expected_samples.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: regression for the nco mixer channel
// Drives corner samples and register settings, then random sample streams
// under several settings with random stalls on both sides; the checker
// predicts every sample and the verdict comes from its error count.
// ----------------------------------------------------------------------------
module tb;
    import ncomix_pkg::*;

    localparam int SW        = SAMPLE_WIDTH_DEF;
    localparam int LIMIT     = 200000;
    localparam int SETTLE    = PIPE_DEPTH + 4;
    localparam int PHASES    = 5;
    localparam int PER_PHASE = 100;

    logic                    clk       = 1'b0;
    logic                    rst_n     = 1'b0;
    logic                    cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0]   cfg_addr  = '0;
    logic [CFG_DATA_W-1:0]   cfg_wdata = '0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic signed [SW-1:0]    in_i      = '0;
    logic signed [SW-1:0]    in_q      = '0;
    logic signed [NOISE_W-1:0] noise_i = '0;
    logic signed [NOISE_W-1:0] noise_q = '0;
    logic                    last_in   = 1'b0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic signed [SW-1:0]    out_i;
    logic signed [SW-1:0]    out_q;
    logic                    last_out;
    int                      errors;
    int                      pending;
    int                      cycles    = 0;
    bit                      steady    = 1'b0;

    always #5 clk = ~clk;

    nco_mixer_gain_noise_channel dut (.*);

    mixer_checker chk (.*);

    always @(posedge clk)
        out_ready <= steady || ($urandom_range(99) >= 35);

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic write_reg(cfg_reg_t r, logic [31:0] v);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= r;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    // valid stays high between back-to-back requests
    task automatic push_sample(logic [SW-1:0] i, logic [SW-1:0] q,
                               logic [15:0] ni, logic [15:0] nq, logic l);
        if (!steady && $urandom_range(99) < 35) begin
            in_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < 35);
        end
        in_valid <= 1'b1;
        in_i     <= i;
        in_q     <= q;
        noise_i  <= ni;
        noise_q  <= nq;
        last_in  <= l;
        do @(posedge clk); while (!in_ready);
    endtask

    // hold off until every sample is back and the pipe is empty
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (pending != 0);
        repeat (SETTLE) @(posedge clk);
    endtask

    function automatic logic [15:0] rand_word();
        case ($urandom_range(9))
            0:       return 16'h7FFF;
            1:       return 16'h8000;
            2:       return 16'h0000;
            3:       return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [15:0] rand_noise();
        if ($urandom_range(3) != 0)
            return 16'(int'($urandom_range(16383)) - 8192);
        return rand_word();
    endfunction

    initial begin : stimulus
        logic [31:0] tgt;
        logic [15:0] alpha;
        logic [15:0] gain;
        logic [15:0] nscale;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: unity gain, no noise, phase held at zero
        push_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h8000, 1'b0);
        push_sample(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b1);
        push_sample(16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 1'b0);
        push_sample(16'h0000, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
        drain();

        // full gain and noise, fast ramp to a quarter turn walks the quadrants
        write_reg(REG_SIGNAL_GAIN, 32'hFFFFFFFF);
        write_reg(REG_NOISE_SCALE, 32'h0000FFFF);
        write_reg(REG_SMOOTHING, 32'h0000FFFF);
        write_reg(REG_TARGET_STEP, 32'h40000000);
        push_sample(16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 1'b0);
        push_sample(16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 1'b1);
        push_sample(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 1'b0);
        push_sample(16'h0001, 16'hFFFF, 16'h7FFF, 16'h8000, 1'b1);
        push_sample(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 1'b0);
        push_sample(16'h1234, 16'hEDCB, 16'h0001, 16'hFFFF, 1'b1);
        drain();

        // signal muted, tiny noise, half-speed ramp to the most negative step
        write_reg(REG_SIGNAL_GAIN, 32'hABCD0000);
        write_reg(REG_NOISE_SCALE, 32'h00000001);
        write_reg(REG_SMOOTHING, 32'h00008000);
        write_reg(REG_TARGET_STEP, 32'h80000000);
        push_sample(16'h7FFF, 16'h7FFF, 16'h0004, 16'hFFFC, 1'b0);
        push_sample(16'h8000, 16'h8000, 16'h0010, 16'hFFF0, 1'b0);
        push_sample(16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 1'b1);
        push_sample(16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 1'b0);
        push_sample(16'h5555, 16'hAAAA, 16'h0800, 16'hF800, 1'b1);
        drain();

        // slowest ramp toward the largest positive step, half gain
        write_reg(REG_SIGNAL_GAIN, 32'h00000080);
        write_reg(REG_NOISE_SCALE, 32'h00000000);
        write_reg(REG_SMOOTHING, 32'hFFFF0001);
        write_reg(REG_TARGET_STEP, 32'h7FFFFFFF);
        push_sample(16'h7FFF, 16'h7FFF, 16'h1000, 16'hF000, 1'b0);
        push_sample(16'h8000, 16'h0000, 16'h0000, 16'h0000, 1'b1);
        push_sample(16'h4000, 16'hC000, 16'h0000, 16'h0000, 1'b0);
        push_sample(16'hFFFF, 16'h0001, 16'h0000, 16'h0000, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case ($urandom_range(3))
                0:       tgt = 32'h7FFFFFFF;
                1:       tgt = 32'h80000000;
                default: tgt = $urandom;
            endcase
            case ($urandom_range(3))
                0:       alpha = 16'h0000;
                1:       alpha = 16'hFFFF;
                default: alpha = 16'($urandom);
            endcase
            case ($urandom_range(3))
                0:       gain = 16'h0000;
                1:       gain = 16'hFFFF;
                default: gain = 16'($urandom_range(512));
            endcase
            case ($urandom_range(3))
                0:       nscale = 16'hFFFF;
                1:       nscale = 16'h0000;
                default: nscale = 16'($urandom_range(64));
            endcase
            // junk in the upper bits must be dropped
            write_reg(REG_TARGET_STEP, tgt);
            write_reg(REG_SMOOTHING, {16'($urandom), alpha});
            write_reg(REG_SIGNAL_GAIN, {16'($urandom), gain});
            write_reg(REG_NOISE_SCALE, {16'($urandom), nscale});
            steady <= (p == 2);
            for (int n = 0; n < PER_PHASE; n++)
                push_sample(rand_word(), rand_word(), rand_noise(), rand_noise(),
                            1'($urandom));
        end
        drain();

        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
